// File: src/fbvs_pkg.sv
// Package for the flag bitmap and value store.
// Sizes, address widths, operation codes and the structs passed between modules.
`timescale 1ns / 1ps
package fbvs_pkg;

  localparam int FLAG_CAPACITY  = 1024;
  localparam int VALUE_CAPACITY = 1024;

  localparam int FLAG_DEPTH = (FLAG_CAPACITY + 7) / 8;
  localparam int FLAG_AW    = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;
  localparam int VAL_AW     = (VALUE_CAPACITY > 1) ? $clog2(VALUE_CAPACITY) : 1;
  localparam int CLR_DEPTH  = (FLAG_DEPTH > VALUE_CAPACITY) ? FLAG_DEPTH : VALUE_CAPACITY;
  localparam int CLR_AW     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  localparam int CNT_W  = 11;
  localparam int IDX_W  = 16;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

  typedef enum logic [0:0] {
    REG_FLAG_COUNT  = 1'b0,
    REG_VALUE_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_SET        = 3'd1,
    OP_TOGGLE     = 3'd2,
    OP_READ_BIT   = 3'd3,
    OP_READ_BYTE  = 3'd4,
    OP_WRITE_VAL  = 3'd5,
    OP_READ_VAL   = 3'd6,
    OP_FLAG_NOP   = 3'd7
  } op_t;

  typedef struct packed {
    logic              active;
    logic [CLR_AW-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
  } exec_res_t;

  typedef struct packed {
    logic       flag_we;
    logic [7:0] flag_wdata;
    logic       val_we;
  } exec_wr_t;

endpackage

// File: src/fbvs_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fbvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fbvs_clear.sv
// Post-reset clearing sequencer: walks both stores, one address a cycle.
// Depends on fbvs_pkg.
`timescale 1ns / 1ps
module fbvs_clear (
  input  logic          clk,
  input  logic          rst,
  output fbvs_pkg::clr_t clr
);
  import fbvs_pkg::*;

  logic              active;
  logic [CLR_AW-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      addr   <= '0;
    end else if (active) begin
      if (addr == CLR_AW'(CLR_DEPTH - 1)) begin
        active <= 1'b0;
      end
      addr <= addr + 1'b1;
    end
  end

  assign clr.active = active;
  assign clr.addr   = addr;

endmodule

// File: src/fbvs_exec.sv
// Execute logic: range checks, flag byte update and result for one request.
// Depends on fbvs_pkg.
`timescale 1ns / 1ps
module fbvs_exec (
  input  fbvs_pkg::op_t                    op,
  input  logic                             neg,
  input  logic [14:0]                      idx,
  input  logic [7:0]                       fbyte,
  input  logic [fbvs_pkg::DATA_W-1:0]      vword,
  input  logic [fbvs_pkg::CNT_W-1:0]       flag_count,
  input  logic [fbvs_pkg::CNT_W-1:0]       value_count,
  output fbvs_pkg::exec_res_t              res,
  output fbvs_pkg::exec_wr_t               wr
);
  import fbvs_pkg::*;

  logic [31:0] idx32;
  logic [31:0] cnt_f;
  logic [31:0] cnt_v;
  logic [31:0] eff_f;
  logic [31:0] eff_v;
  logic [31:0] nbytes;
  logic        flag_ok;
  logic        byte_ok;
  logic        val_ok;
  logic [7:0]  bitmask;

  // counts above capacity saturate
  assign idx32  = {17'b0, idx};
  assign cnt_f  = {{(32 - CNT_W){1'b0}}, flag_count};
  assign cnt_v  = {{(32 - CNT_W){1'b0}}, value_count};
  assign eff_f  = (cnt_f > 32'(FLAG_CAPACITY)) ? 32'(FLAG_CAPACITY) : cnt_f;
  assign eff_v  = (cnt_v > 32'(VALUE_CAPACITY)) ? 32'(VALUE_CAPACITY) : cnt_v;
  assign nbytes = (eff_f + 32'd7) >> 3;

  assign flag_ok = !neg && (idx32 < eff_f) && ((idx32 >> 3) < 32'(FLAG_DEPTH));
  assign byte_ok = !neg && (idx32 < nbytes) && (idx32 < 32'(FLAG_DEPTH));
  assign val_ok  = !neg && (idx32 < eff_v) && (idx32 < 32'(VALUE_CAPACITY));
  assign bitmask = 8'b1 << idx[2:0];

  always_comb begin
    res           = '0;
    wr            = '0;
    wr.flag_wdata = fbyte;
    case (op)
      OP_CLEAR: begin
        res.ok        = flag_ok;
        wr.flag_we    = flag_ok;
        wr.flag_wdata = fbyte & ~bitmask;
      end
      OP_SET: begin
        res.ok        = flag_ok;
        wr.flag_we    = flag_ok;
        wr.flag_wdata = fbyte | bitmask;
      end
      OP_TOGGLE: begin
        res.ok        = flag_ok;
        wr.flag_we    = flag_ok;
        wr.flag_wdata = fbyte ^ bitmask;
      end
      OP_READ_BIT: begin
        res.ok = flag_ok;
        if (flag_ok) begin
          res.data = {{(DATA_W - 1){1'b0}}, fbyte[idx[2:0]]};
        end
      end
      OP_READ_BYTE: begin
        res.ok = byte_ok;
        if (byte_ok) begin
          res.data = {{(DATA_W - 8){1'b0}}, fbyte};
        end
      end
      OP_WRITE_VAL: begin
        res.ok    = val_ok;
        wr.val_we = val_ok;
      end
      OP_READ_VAL: begin
        res.ok = val_ok;
        if (val_ok) begin
          res.data = vword;
        end
      end
      OP_FLAG_NOP: begin
        res.ok = flag_ok;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// File: src/flag_bitmap_value_store.sv
// Flag bitmap and signed value store.
// The request is registered in s1, the result at the output when s1 advances.
// Throughput: one request per cycle while out_stall is low; flag updates are
// read-modify-write across the RAM read stage, with write-to-read forwarding for
// back-to-back requests. Reset: counts go to 1024, then a clearing pass over max(flag
// bytes, value slots) addresses (1024) zeroes both stores; requests stall during it.
`timescale 1ns / 1ps
module flag_bitmap_value_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [fbvs_pkg::CNT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        op,
  input  logic signed [fbvs_pkg::IDX_W-1:0] index,
  input  logic signed [fbvs_pkg::DATA_W-1:0] write_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic signed [fbvs_pkg::DATA_W-1:0] read_data
);
  import fbvs_pkg::*;

  logic [CNT_W-1:0] flag_count;
  logic [CNT_W-1:0] value_count;

  clr_t      clr;
  exec_res_t res;
  exec_wr_t  wr;

  logic               accept;
  logic               adv;
  logic [31:0]        idx_in;
  logic [FLAG_AW-1:0] faddr_in;
  logic [VAL_AW-1:0]  vaddr_in;

  logic               s1_valid;
  op_t                s1_op;
  logic               s1_neg;
  logic [14:0]        s1_idx;
  logic [DATA_W-1:0]  s1_wval;
  logic [FLAG_AW-1:0] s1_faddr;
  logic [VAL_AW-1:0]  s1_vaddr;

  logic               fbyp;
  logic [7:0]         fbyp_data;
  logic               vbyp;
  logic [DATA_W-1:0]  vbyp_data;

  logic [7:0]         f_rdata;
  logic [DATA_W-1:0]  v_rdata;
  logic [7:0]         fbyte;
  logic [DATA_W-1:0]  vword;

  logic               f_we;
  logic [FLAG_AW-1:0] f_waddr;
  logic [7:0]         f_wdata;
  logic               v_we;
  logic [VAL_AW-1:0]  v_waddr;
  logic [DATA_W-1:0]  v_wdata;
  logic               f_upd;
  logic               v_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_count  <= COUNT_RESET;
      value_count <= COUNT_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FLAG_COUNT:  flag_count  <= cfg_data;
        REG_VALUE_COUNT: value_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fbvs_clear u_clear (
    .clk (clk),
    .rst (rst),
    .clr (clr)
  );

  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clr.active || (s1_valid && !adv);
  assign accept   = in_valid && !in_stall;

  // bit ops address the byte holding the flag, byte reads address it directly
  assign idx_in   = {17'b0, index[14:0]};
  assign faddr_in = (op_t'(op) == OP_READ_BYTE) ? idx_in[FLAG_AW-1:0] : idx_in[FLAG_AW+2:3];
  assign vaddr_in = idx_in[VAL_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  assign f_upd = adv && wr.flag_we;
  assign v_upd = adv && wr.val_we;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= op_t'(op);
      s1_neg    <= index[IDX_W-1];
      s1_idx    <= index[14:0];
      s1_wval   <= write_value;
      s1_faddr  <= faddr_in;
      s1_vaddr  <= vaddr_in;
      // RAM read is read-first; forward a write landing on the same edge
      fbyp      <= f_upd && (s1_faddr == faddr_in);
      fbyp_data <= wr.flag_wdata;
      vbyp      <= v_upd && (s1_vaddr == vaddr_in);
      vbyp_data <= s1_wval;
    end
  end

  assign fbyte = fbyp ? fbyp_data : f_rdata;
  assign vword = vbyp ? vbyp_data : v_rdata;

  fbvs_exec u_exec (
    .op          (s1_op),
    .neg         (s1_neg),
    .idx         (s1_idx),
    .fbyte       (fbyte),
    .vword       (vword),
    .flag_count  (flag_count),
    .value_count (value_count),
    .res         (res),
    .wr          (wr)
  );

  always_comb begin
    if (clr.active) begin
      f_we    = (clr.addr < CLR_AW'(FLAG_DEPTH)) || (CLR_DEPTH == FLAG_DEPTH);
      f_waddr = clr.addr[FLAG_AW-1:0];
      f_wdata = '0;
      v_we    = (clr.addr < CLR_AW'(VALUE_CAPACITY)) || (CLR_DEPTH == VALUE_CAPACITY);
      v_waddr = clr.addr[VAL_AW-1:0];
      v_wdata = '0;
    end else begin
      f_we    = f_upd;
      f_waddr = s1_faddr;
      f_wdata = wr.flag_wdata;
      v_we    = v_upd;
      v_waddr = s1_vaddr;
      v_wdata = s1_wval;
    end
  end

  fbvs_ram #(
    .WIDTH (8),
    .DEPTH (FLAG_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (accept),
    .raddr (faddr_in),
    .rdata (f_rdata)
  );

  fbvs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VALUE_CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (accept),
    .raddr (vaddr_in),
    .rdata (v_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok        <= res.ok;
      read_data <= res.data;
    end
  end

endmodule

// File: test/testbench.sv
// Testbench for flag_bitmap_value_store: directed and random flag and value requests.
// A predictor class keeps its own copy of the flag bitmap, the value table and the counts.
// Depends on fbvs_pkg for the sizes, operation and register codes and result struct.
`timescale 1ns / 1ps
module testbench;
  import fbvs_pkg::*;

  class store_predictor;
    logic [7:0]        flag_bytes [FLAG_DEPTH];
    logic [DATA_W-1:0] value_table [VALUE_CAPACITY];
    logic [CNT_W-1:0]  flag_count;
    logic [CNT_W-1:0]  value_count;
    exec_res_t         awaited_answers [$];
    int                errors;

    function new();
      foreach (flag_bytes[i]) flag_bytes[i] = '0;
      foreach (value_table[i]) value_table[i] = '0;
      flag_count  = COUNT_RESET;
      value_count = COUNT_RESET;
      errors      = 0;
    endfunction

    function int unsigned flags_in_use();
      return (flag_count > FLAG_CAPACITY) ? FLAG_CAPACITY : flag_count;
    endfunction

    function int unsigned values_in_use();
      return (value_count > VALUE_CAPACITY) ? VALUE_CAPACITY : value_count;
    endfunction

    function void write_reg(reg_idx_t r, logic [CNT_W-1:0] v);
      case (r)
        REG_FLAG_COUNT:  flag_count  = v;
        REG_VALUE_COUNT: value_count = v;
        default: ;
      endcase
    endfunction

    // works out the answer to one accepted request and applies its update
    function void note_request(op_t o, logic [IDX_W-1:0] ix, logic [DATA_W-1:0] wv);
      int unsigned fc      = flags_in_use();
      int unsigned vc      = values_in_use();
      int unsigned n       = ix[IDX_W-2:0];
      int unsigned byte_no = n >> 3;
      int unsigned bit_pos = n & 7;
      exec_res_t   ans;
      ans.ok   = 1'b0;
      ans.data = '0;
      if (!ix[IDX_W-1]) begin
        case (o)
          OP_CLEAR, OP_SET, OP_TOGGLE, OP_READ_BIT, OP_FLAG_NOP: begin
            if (n < fc && byte_no < FLAG_DEPTH) begin
              ans.ok = 1'b1;
              case (o)
                OP_CLEAR:    flag_bytes[byte_no][bit_pos] = 1'b0;
                OP_SET:      flag_bytes[byte_no][bit_pos] = 1'b1;
                OP_TOGGLE:   flag_bytes[byte_no][bit_pos] = ~flag_bytes[byte_no][bit_pos];
                OP_READ_BIT: ans.data = DATA_W'(flag_bytes[byte_no][bit_pos]);
                default: ;
              endcase
            end
          end
          OP_READ_BYTE: begin
            // bound is ceil(count/8); stale bits above the count are still returned
            if (n < (fc + 7) / 8 && n < FLAG_DEPTH) begin
              ans.ok   = 1'b1;
              ans.data = DATA_W'(flag_bytes[n]);
            end
          end
          default: begin
            if (n < vc && n < VALUE_CAPACITY) begin
              ans.ok = 1'b1;
              if (o == OP_WRITE_VAL) value_table[n] = wv;
              else ans.data = value_table[n];
            end
          end
        endcase
      end
      awaited_answers.push_back(ans);
    endfunction

    task report(string msg);
      $display("%0t store check: %s", $time, msg);
      errors++;
    endtask

    task check_answer(logic got_ok, logic [DATA_W-1:0] got_data);
      exec_res_t exp;
      if (awaited_answers.size() == 0) begin
        report($sformatf("result with nothing awaited (ok=%0b data=%h)", got_ok, got_data));
      end else begin
        exp = awaited_answers.pop_front();
        if (got_ok !== exp.ok)
          report($sformatf("ok %b, expected %b", got_ok, exp.ok));
        if (got_data !== exp.data)
          report($sformatf("read_data %h, expected %h", got_data, exp.data));
      end
    endtask

    function int pending();
      return awaited_answers.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [0:0]               cfg_index;
  logic [CNT_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               op;
  logic signed [IDX_W-1:0]  index;
  logic signed [DATA_W-1:0] write_value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     ok;
  logic signed [DATA_W-1:0] read_data;

  store_predictor sb = new();
  int             send_idle_pct;
  int             recv_idle_pct;

  flag_bitmap_value_store i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .index       (index),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .read_data   (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_answer(ok, read_data);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(op_t o, logic [IDX_W-1:0] ix, logic [DATA_W-1:0] wv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    op          = o;
    index       = ix;
    write_value = wv;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(o, ix, wv);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [CNT_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_index = r;
    cfg_data  = v;
    @(posedge clk);
    sb.write_reg(r, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_counts(logic [CNT_W-1:0] fc, logic [CNT_W-1:0] vc);
    wait_drain();
    write_reg(REG_FLAG_COUNT, fc);
    write_reg(REG_VALUE_COUNT, vc);
  endtask

  task automatic random_request();
    op_t               o;
    logic [IDX_W-1:0]  ix;
    logic [DATA_W-1:0] wv;
    int unsigned       lim;
    o = op_t'($urandom_range(7));
    case (o)
      OP_READ_BYTE:             lim = (sb.flags_in_use() + 7) / 8 + 1;
      OP_WRITE_VAL, OP_READ_VAL: lim = sb.values_in_use() + 1;
      default:                  lim = sb.flags_in_use() + 1;
    endcase
    case ($urandom_range(9))
      0, 1, 2: ix = IDX_W'($urandom_range(lim));
      3, 4, 5: ix = IDX_W'($urandom_range(40));     // hot window so reads see earlier writes
      6:       ix = IDX_W'($urandom) | 16'h8000;
      7:       ix = IDX_W'($urandom);
      8: begin
        case ($urandom_range(3))
          0:       ix = 16'h7fff;
          1:       ix = 16'h8000;
          2:       ix = 16'hffff;
          default: ix = 16'h0000;
        endcase
      end
      default: ix = IDX_W'(lim - 1 - $urandom_range(1));   // either side of the bound
    endcase
    case ($urandom_range(7))
      0:       wv = 32'h7fffffff;
      1:       wv = 32'h80000000;
      2:       wv = 32'hffffffff;
      3:       wv = 32'h00000000;
      default: wv = $urandom;
    endcase
    send_request(o, ix, wv);
  endtask

  initial begin
    int unsigned flag_settings [9];
    int unsigned value_settings [9];
    int unsigned fc;
    int unsigned vc;
    flag_settings  = '{1024, 0, 2047, 13, 1, 1023, 8, 0, 1024};
    value_settings = '{1024, 0, 2047, 700, 1, 1025, 9, 0, 1024};
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_FLAG_COUNT;
    cfg_data      = '0;
    in_valid      = 1'b0;
    op            = OP_CLEAR;
    index         = '0;
    write_value   = '0;
    out_stall     = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 58;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset counts, bounds, negative indices, data extremes
    send_request(OP_SET, 16'd0, '0);
    send_request(OP_SET, 16'd1023, '0);
    send_request(OP_SET, 16'd15, '0);
    send_request(OP_READ_BIT, 16'd1023, '0);
    send_request(OP_READ_BYTE, 16'd127, '0);
    send_request(OP_READ_BYTE, 16'd128, '0);
    send_request(OP_TOGGLE, 16'd7, '0);
    send_request(OP_READ_BYTE, 16'd0, '0);
    send_request(OP_CLEAR, 16'd0, '0);
    send_request(OP_READ_BIT, 16'd0, '0);
    send_request(OP_SET, 16'd1024, '0);
    send_request(OP_SET, 16'hffff, '0);
    send_request(OP_READ_VAL, 16'h8000, '0);
    send_request(OP_WRITE_VAL, 16'h7fff, 32'h12345678);
    send_request(OP_WRITE_VAL, 16'd0, 32'h7fffffff);
    send_request(OP_WRITE_VAL, 16'd1023, 32'h80000000);
    send_request(OP_READ_VAL, 16'd1023, '0);
    send_request(OP_READ_VAL, 16'd1024, '0);
    send_request(OP_FLAG_NOP, 16'd1023, '0);
    send_request(OP_FLAG_NOP, 16'd1024, '0);
    // shrunk counts: flag 15 stays visible through the byte read
    set_counts(11'd13, 11'd0);
    send_request(OP_READ_BYTE, 16'd1, '0);
    send_request(OP_READ_BYTE, 16'd2, '0);
    send_request(OP_SET, 16'd13, '0);
    send_request(OP_READ_VAL, 16'd0, '0);
    // counts above capacity saturate
    set_counts(11'd2047, 11'd2047);
    send_request(OP_READ_BIT, 16'd1023, '0);
    send_request(OP_READ_VAL, 16'd1023, '0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 17 : 0;
      for (int sub = 0; sub < 3; sub++) begin
        fc = flag_settings[ph * 3 + sub];
        vc = value_settings[ph * 3 + sub];
        if (ph * 3 + sub == 7) begin
          fc = $urandom_range(2047);
          vc = $urandom_range(2047);
        end
        set_counts(CNT_W'(fc), CNT_W'(vc));
        for (int k = 0; k < 105; k++) begin
          if (k == 52) wait_drain();
          random_request();
        end
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
src/fbvs_pkg.sv
src/fbvs_ram.sv
src/fbvs_clear.sv
src/fbvs_exec.sv
src/flag_bitmap_value_store.sv
test/testbench.sv
